[sv/svle_pkg.sv]
package svle_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 5;
    localparam int TOTAL_W = 6;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_SORT   = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

endpackage

[sv/sorted_value_list_engine.sv]
// Channel   | Signals                          | Word
// ----------+----------------------------------+------------------------------------------
// s_axis    | tvalid tready tdata[39:0] tuser  | tdata: item_value, read_index; tuser: action
// m_axis    | tvalid tready tdata[71:0] tuser  | tdata: read_value, entry_total, value_sum;
//           |                                  | tuser: status
//
// Append, read, insert on a full list, sort of 0-1 entries, unused actions: no walk.
// Insert and delete walk the list through the single read port.
// Sort: bubble passes until one makes no swap (at most count passes), then finish.
// Reset clears count, sum and control; memory is not cleared.
// One item at a time; the next word is taken while a result waits in the output
// register, and a finished item holds until that register is free.
module sorted_value_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] item_value, [36:32] read_index
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] read_value, [37:32] entry_total,
                                        // [69:38] value_sum
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import svle_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    action_t         op_reg, op_next;
    value_t          val_reg, val_next;
    logic [CW-1:0]   idx_reg, idx_next;
    value_t          carry_reg, carry_next;
    logic            found_reg, found_next;
    logic            swapped_reg, swapped_next;
    logic [CW-1:0]   count_reg, count_next;
    value_t          sum_reg, sum_next;
    status_t         status_reg, status_next;
    logic            rdok_reg, rdok_next;

    logic            m_valid_reg, m_valid_next;
    status_t         m_status_reg;
    value_t          m_rdval_reg;
    logic [TOTAL_W-1:0] m_total_reg;
    value_t          m_sum_reg;
    logic            m_load;

    value_t          mem [CAPACITY];
    value_t          rd_data_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    value_t          mem_wdata;

    action_t         in_action;
    value_t          in_value;
    logic [INDEX_W-1:0] in_index;
    logic            at_end, full, out_free;

    assign in_action = action_t'(s_axis_tuser);
    assign in_value  = value_t'(s_axis_tdata[31:0]);
    assign in_index  = s_axis_tdata[36:32];

    assign at_end   = (idx_reg == count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign out_free = !m_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);

    // Walks write at idx or idx-1 and read idx+1 (or 0 on a new sort pass while
    // writing count-1 >= 1), so a read never meets a write to the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        carry_next   = carry_reg;
        found_next   = found_reg;
        swapped_next = swapped_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        status_next  = status_reg;
        rdok_next    = rdok_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = val_reg;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        m_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next      = in_action;
                    val_next     = in_value;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    swapped_next = 1'b0;
                    status_next  = ST_OK;
                    rdok_next    = 1'b0;
                    state_next   = S_FINISH;
                    case (in_action)
                        ACT_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = in_value;
                                count_next = count_reg + CW'(1);
                                sum_next   = sum_reg + in_value;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        ACT_DELETE:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_WALK;
                        end
                        ACT_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                mem_re     = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        ACT_READ:
                        begin
                            if (int'(in_index) < int'(count_reg))
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(in_index);
                                rdok_next = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // rd_data_reg holds mem[idx_reg] while idx_reg < count
                if (!at_end)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_reg + CW'(1));
                    idx_next  = idx_reg + CW'(1);
                end
                case (op_reg)
                    ACT_INSERT:
                    begin
                        if (at_end)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(idx_reg);
                            mem_wdata  = found_reg ? carry_reg : val_reg;
                            count_next = count_reg + CW'(1);
                            sum_next   = sum_reg + val_reg;
                            state_next = S_FINISH;
                        end
                        else if (found_reg || (rd_data_reg < val_reg))
                        begin
                            // shift everything from the insertion point one place down
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(idx_reg);
                            mem_wdata  = found_reg ? carry_reg : val_reg;
                            carry_next = rd_data_reg;
                            found_next = 1'b1;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (at_end)
                        begin
                            if (found_reg)
                            begin
                                count_next = count_reg - CW'(1);
                                sum_next   = sum_reg - val_reg;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            state_next = S_FINISH;
                        end
                        else if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(idx_reg - CW'(1));
                            mem_wdata = rd_data_reg;
                        end
                        else if (rd_data_reg == val_reg)
                        begin
                            found_next = 1'b1;
                        end
                    end
                    ACT_SORT:
                    begin
                        // bubble pass: carry the smaller value toward the tail
                        if (at_end)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(idx_reg - CW'(1));
                            mem_wdata = carry_reg;
                            if (swapped_reg)
                            begin
                                mem_re       = 1'b1;
                                mem_raddr    = '0;
                                idx_next     = '0;
                                swapped_next = 1'b0;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        else if (idx_reg == '0)
                        begin
                            carry_next = rd_data_reg;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(idx_reg - CW'(1));
                            if (rd_data_reg > carry_reg)
                            begin
                                mem_wdata    = rd_data_reg;
                                swapped_next = 1'b1;
                            end
                            else
                            begin
                                mem_wdata  = carry_reg;
                                carry_next = rd_data_reg;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (m_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        carry_reg   <= carry_next;
        found_reg   <= found_next;
        swapped_reg <= swapped_next;
        status_reg  <= status_next;
        rdok_reg    <= rdok_next;
        if (m_load)
        begin
            m_status_reg <= status_reg;
            m_rdval_reg  <= rdok_reg ? rd_data_reg : '0;
            m_total_reg  <= TOTAL_W'(count_reg);
            m_sum_reg    <= sum_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_sum_reg, m_total_reg, m_rdval_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

[sv/svle_checker.sv]
module svle_checker #(
    parameter int CAPACITY = 32
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import svle_pkg::*;

    // a held result word does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

    // one item at a time: accepting a word closes the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

    // a failed action returns no read data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[31:0] == '0)
    else $error("read_value nonzero on a failed action");

    // full is only reported with the list at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[37:32] == 6'(CAPACITY))
    else $error("full reported below capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (CAPACITY > 63) || (int'(m_axis_tdata[37:32]) <= CAPACITY))
    else $error("entry_total beyond capacity");

endmodule

bind sorted_value_list_engine svle_checker #(.CAPACITY(CAPACITY)) u_svle_checker (.*);
